FILE: design/bsf_pkg.sv
// Shared constants, queue entry type and escape helpers for the byte
// stuffing framer. No dependencies.
`timescale 1ns / 1ps

package bsf_pkg;

   // Line codes
   localparam logic [7:0] FLAG_BYTE   = 8'h7E;
   localparam logic [7:0] ESC_BYTE    = 8'h7D;
   localparam logic [7:0] ESC_OF_FLAG = 8'h02;
   localparam logic [7:0] ESC_OF_ESC  = 8'h01;

   // Default depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // One classified payload byte, as handed from front to back
   typedef struct packed {
      logic [7:0] data;       // raw payload byte
      logic       last;       // closes the frame
      logic       open;       // opens the frame
      logic [7:0] check;      // check byte, valid when last is set
   } entry_type;

   // Byte needs a two-byte escape sequence on the line
   function automatic logic needs_escape(input logic [7:0] b);
      return (b == FLAG_BYTE) || (b == ESC_BYTE);
   endfunction

   // Second byte of the escape sequence for an escaped byte
   function automatic logic [7:0] escape_code(input logic [7:0] b);
      return (b == FLAG_BYTE) ? ESC_OF_FLAG : ESC_OF_ESC;
   endfunction

endpackage

FILE: design/byte_stuffing_framer_xor_check.sv
// Byte stuffing framer with XOR check: 0x7E flags, 0x7D escapes.
// An item passes the front entry register, the queue, the back-end current entry
// and the output register. The back end emits one line byte per cycle unless the
// receiver holds off, so an item yields 1 to 6 line bytes (1 or 2 for data, plus
// flags and check). Reset (synchronous, active high) closes any open frame,
// reseeds the check with 0x7E and empties the queue and output register.
`timescale 1ns / 1ps

module byte_stuffing_framer_xor_check
   import bsf_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // frame_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,   // run_last
   output logic       rsp_tuser    // [0] frame_end
);

   logic      front_valid, front_ready;
   entry_type front_entry;
   logic      queue_valid, queue_ready;
   entry_type queue_entry;

   // Classify bytes and track the check
   bsf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .in_last   (req_tlast),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_entry (front_entry)
   );

   // Buffer entries between front and back
   bsf_queue #(
      .DEPTH (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_entry (front_entry),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_entry  (queue_entry)
   );

   // Emit the line bytes
   bsf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (queue_valid),
      .in_ready  (queue_ready),
      .in_entry  (queue_entry),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_last  (rsp_tlast),
      .out_end   (rsp_tuser)
   );

endmodule

FILE: design/bsf_front.sv
// Front end of the framer: accepts payload bytes, tracks the open frame
// and the running XOR check, and registers one classified entry.
// Depends on bsf_pkg.
`timescale 1ns / 1ps

module bsf_front
   import bsf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_data,
   input  logic       in_last,
   output logic       out_valid,
   input  logic       out_ready,
   output entry_type  out_entry
);

   logic       in_frame_ff, in_frame_in;
   logic [7:0] check_ff, check_in;
   logic       valid_ff, valid_in;
   entry_type  entry_ff, entry_in;
   logic       take;
   logic       opening;
   logic [7:0] check_now;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   // Classify the incoming byte and fold it into the check
   always_comb begin
      opening   = !in_frame_ff;
      check_now = (opening ? FLAG_BYTE : check_ff) ^ in_data;

      in_frame_in = in_frame_ff;
      check_in    = check_ff;
      entry_in    = entry_ff;
      valid_in    = valid_ff && !out_ready;
      if (take) begin
         in_frame_in    = !in_last;
         check_in       = in_last ? FLAG_BYTE : check_now;
         entry_in.data  = in_data;
         entry_in.last  = in_last;
         entry_in.open  = opening;
         entry_in.check = check_now;
         valid_in       = 1'b1;
      end
   end

   // Hold frame state and the entry register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         check_ff    <= FLAG_BYTE;
         valid_ff    <= 1'b0;
      end else begin
         in_frame_ff <= in_frame_in;
         check_ff    <= check_in;
         valid_ff    <= valid_in;
      end
      entry_ff <= entry_in;
   end

   assign out_valid = valid_ff;
   assign out_entry = entry_ff;

endmodule

FILE: design/bsf_queue.sv
// Short entry queue that decouples the framer's front and back.
// Depends on bsf_pkg.
`timescale 1ns / 1ps

module bsf_queue
   import bsf_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  entry_type push_entry,
   output logic      pop_valid,
   input  logic      pop_ready,
   output entry_type pop_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   entry_type        store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_entry  = store_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write the entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: design/bsf_back.sv
// Back end of the framer: sequences an opening flag for an entry that
// opens a frame, escaped data, and escaped check and closing flag for
// one that closes it, into a registered output. Depends on bsf_pkg.
`timescale 1ns / 1ps

module bsf_back
   import bsf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  entry_type  in_entry,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [7:0] out_byte,
   output logic       out_last,
   output logic       out_end
);

   typedef enum logic [2:0] {
      PH_OPEN,
      PH_DATA_A,
      PH_DATA_B,
      PH_CHK_A,
      PH_CHK_B,
      PH_CLOSE
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic       cur_valid_ff, cur_valid_in;
   entry_type  cur_ff, cur_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_last_ff, out_last_in;
   logic       out_end_ff, out_end_in;

   logic       advance;
   logic       done;
   logic       load;
   logic [7:0] emit_byte;
   logic       emit_end;
   phase_type  step_phase;

   assign advance = !out_valid_ff || out_ready;

   // Work out the byte for the current phase and where to go next
   always_comb begin
      emit_byte  = FLAG_BYTE;
      emit_end   = 1'b0;
      done       = 1'b0;
      step_phase = phase_ff;
      case (phase_ff)
         PH_OPEN: begin
            emit_byte  = FLAG_BYTE;
            step_phase = PH_DATA_A;
         end
         PH_DATA_A: begin
            if (needs_escape(cur_ff.data)) begin
               emit_byte  = ESC_BYTE;
               step_phase = PH_DATA_B;
            end else begin
               emit_byte  = cur_ff.data;
               step_phase = PH_CHK_A;
               done       = !cur_ff.last;
            end
         end
         PH_DATA_B: begin
            emit_byte  = escape_code(cur_ff.data);
            step_phase = PH_CHK_A;
            done       = !cur_ff.last;
         end
         PH_CHK_A: begin
            if (needs_escape(cur_ff.check)) begin
               emit_byte  = ESC_BYTE;
               step_phase = PH_CHK_B;
            end else begin
               emit_byte  = cur_ff.check;
               step_phase = PH_CLOSE;
            end
         end
         PH_CHK_B: begin
            emit_byte  = escape_code(cur_ff.check);
            step_phase = PH_CLOSE;
         end
         PH_CLOSE: begin
            emit_byte  = FLAG_BYTE;
            emit_end   = 1'b1;
            done       = 1'b1;
            step_phase = PH_OPEN;
         end
         default: begin
            emit_byte  = FLAG_BYTE;
            step_phase = PH_OPEN;
         end
      endcase
   end

   // Take a new entry when nothing is held or the held one finishes now
   assign load     = advance && (!cur_valid_ff || done);
   assign in_ready = load;

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_in       = cur_ff;
      phase_in     = phase_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_end_in   = out_end_ff;
      if (advance) begin
         out_valid_in = cur_valid_ff;
         out_byte_in  = emit_byte;
         out_last_in  = done;
         out_end_in   = emit_end;
         if (cur_valid_ff && !done) begin
            phase_in = step_phase;
         end
      end
      if (load) begin
         cur_valid_in = in_valid;
         cur_in       = in_entry;
         phase_in     = in_entry.open ? PH_OPEN : PH_DATA_A;
      end
   end

   // Hold sequencer state and the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_OPEN;
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
      end
      cur_ff      <= cur_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_end_ff  <= out_end_in;
   end

   assign out_valid = out_valid_ff;
   assign out_byte  = out_byte_ff;
   assign out_last  = out_last_ff;
   assign out_end   = out_end_ff;

endmodule

FILE: dv/byte_stuffing_framer_xor_check_test.sv
// Self-checking bench for byte_stuffing_framer_xor_check: directed frames, then random
// frames checked against an in-bench framer model, with random stalls on both streams.
// Depends on bsf_pkg and the framer RTL only.
`timescale 1ns / 1ps

module byte_stuffing_framer_xor_check_test
   import bsf_pkg::*;
();

   localparam int RANDOM_ITEMS = 460;
   localparam int SQUEEZE_AFTER = 120;  // results seen before the long receiver hold-off
   localparam int SQUEEZE_CYCLES = 400;
   localparam int DRAIN_CYCLES = 30;

   // One line byte as it leaves the framer
   typedef struct packed {
      logic [7:0] value;
      logic       run_last;
      logic       frame_end;
   } line_byte_type;

   // Directed row: payload byte, last mark, and the typed line bytes (first byte in the
   // top byte of line_seq); byte_count of zero leaves the row to the model
   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic [2:0]  byte_count;
      logic [47:0] line_seq;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 20;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      // one-byte frames from a fresh check: extremes and escape cases
      '{8'h00, 1'b1, 3'd5, 48'h7E_00_7D_02_7E_00},  // check of 0x7E is escaped
      '{8'h7E, 1'b1, 3'd5, 48'h7E_7D_02_00_7E_00},  // flag in the payload
      '{8'h7D, 1'b1, 3'd5, 48'h7E_7D_01_03_7E_00},  // escape in the payload
      '{8'hFF, 1'b1, 3'd4, 48'h7E_FF_81_7E_00_00},
      '{8'h03, 1'b1, 3'd5, 48'h7E_03_7D_01_7E_00},  // check of 0x7D is escaped
      // multi-byte frame
      '{8'h01, 1'b0, 3'd2, 48'h7E_01_00_00_00_00},
      '{8'h7E, 1'b0, 3'd2, 48'h7D_02_00_00_00_00},
      '{8'h7D, 1'b0, 3'd2, 48'h7D_01_00_00_00_00},
      '{8'hFF, 1'b0, 3'd1, 48'hFF_00_00_00_00_00},
      '{8'h00, 1'b0, 3'd1, 48'h00_00_00_00_00_00},
      '{8'h80, 1'b1, 3'd0, 48'h0},
      // frame whose check lands on the flag
      '{8'hAA, 1'b0, 3'd0, 48'h0},
      '{8'h55, 1'b0, 3'd0, 48'h0},
      '{8'hFF, 1'b1, 3'd0, 48'h0},
      // frame whose check lands on the escape, then a one-byte frame
      '{8'h7F, 1'b0, 3'd0, 48'h0},
      '{8'h7C, 1'b1, 3'd0, 48'h0},
      '{8'h01, 1'b1, 3'd0, 48'h0},
      // back-to-back flags cancel in the check
      '{8'h7E, 1'b0, 3'd0, 48'h0},
      '{8'h7E, 1'b0, 3'd0, 48'h0},
      '{8'h7D, 1'b1, 3'd0, 48'h0}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] data_byte
   logic       req_tlast = 1'b0;    // frame_last
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] out_byte
   logic       rsp_tlast;           // run_last
   logic       rsp_tuser;           // [0] frame_end

   // Framer model state and expected line bytes
   logic       frame_open = 1'b0;
   logic [7:0] xor_check = FLAG_BYTE;
   line_byte_type step_bytes[$];
   line_byte_type line_expected[$];

   int mismatch_count = 0;
   int results_seen = 0;

   byte_stuffing_framer_xor_check u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // Gap length: mostly none, some short, a few long; none in a quiet stretch
   function automatic int pick_gap(input bit quiet);
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 55) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(6, 25);
   endfunction

   // Payload byte biased toward the line codes and the extremes
   function automatic logic [7:0] random_payload();
      logic [7:0] picks [4];
      picks = '{FLAG_BYTE, ESC_BYTE, 8'h00, 8'hFF};
      if ($urandom_range(0, 3) == 0) begin
         return picks[$urandom_range(0, 3)];
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // Append one byte to the model output, stuffing flag and escape
   task automatic push_escaped(input logic [7:0] b);
      if (b == FLAG_BYTE) begin
         step_bytes.push_back('{ESC_BYTE, 1'b0, 1'b0});
         step_bytes.push_back('{ESC_OF_FLAG, 1'b0, 1'b0});
      end else if (b == ESC_BYTE) begin
         step_bytes.push_back('{ESC_BYTE, 1'b0, 1'b0});
         step_bytes.push_back('{ESC_OF_ESC, 1'b0, 1'b0});
      end else begin
         step_bytes.push_back('{b, 1'b0, 1'b0});
      end
   endtask

   // Model of one payload transfer: fills step_bytes and advances the frame state
   task automatic frame_payload_byte(input logic [7:0] d, input logic l);
      step_bytes.delete();
      if (!frame_open) begin
         step_bytes.push_back('{FLAG_BYTE, 1'b0, 1'b0});
         xor_check = FLAG_BYTE;
         frame_open = 1'b1;
      end
      xor_check = xor_check ^ d;
      push_escaped(d);
      if (l) begin
         push_escaped(xor_check);
         step_bytes.push_back('{FLAG_BYTE, 1'b0, 1'b1});
         frame_open = 1'b0;
         xor_check = FLAG_BYTE;
      end
      step_bytes[step_bytes.size() - 1].run_last = 1'b1;
   endtask

   // Offer one payload byte after a random gap, wait for the transfer, then queue
   // its line bytes: typed ones when byte_count is set, the model's otherwise
   bit send_quiet = 1'b0;
   int send_count = 0;

   task automatic send_payload(input logic [7:0] d, input logic l,
                               input logic [2:0] byte_count, input logic [47:0] line_seq);
      int gap;
      gap = pick_gap(send_quiet);
      send_count++;
      if (send_count % 40 == 0) begin
         send_quiet = ($urandom_range(0, 2) == 0);
      end
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         req_tdata <= 8'($urandom_range(0, 255));
         req_tlast <= 1'($urandom_range(0, 1));
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      req_tlast <= l;
      do @(posedge clock); while (!req_tready);
      frame_payload_byte(d, l);
      if (byte_count != 0) begin
         for (int i = 0; i < byte_count; i++) begin
            line_expected.push_back('{line_seq[47 - 8 * i -: 8], i == byte_count - 1,
                                      l && (i == byte_count - 1)});
         end
      end else begin
         foreach (step_bytes[i]) line_expected.push_back(step_bytes[i]);
      end
   endtask

   // Check every line byte transfer against the oldest expectation
   always @(posedge clock) begin
      line_byte_type got;
      line_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata, rsp_tlast, rsp_tuser};
         results_seen <= results_seen + 1;
         if (line_expected.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected line byte %h run_last %b frame_end %b",
                        got.value, got.run_last, got.frame_end);
            end
         end else begin
            want = line_expected.pop_front();
            if (got != want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("line byte %0d: expected %h/%b/%b, got %h/%b/%b", results_seen,
                           want.value, want.run_last, want.frame_end,
                           got.value, got.run_last, got.frame_end);
               end
            end
         end
      end
   end

   // Receiver: random hold-offs, quiet stretches, and one long squeeze
   initial begin
      int hold;
      int cycles;
      bit quiet;
      bit squeezed;
      hold = 0;
      cycles = 0;
      quiet = 1'b0;
      squeezed = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         cycles++;
         if (cycles % 64 == 0) begin
            quiet = ($urandom_range(0, 2) == 0);
         end
         if (!squeezed && results_seen >= SQUEEZE_AFTER) begin
            squeezed = 1'b1;
            hold = SQUEEZE_CYCLES;
         end
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            hold--;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
               hold = pick_gap(quiet);
            end
         end
         @(negedge clock);
      end
   end

   // Reset, directed rows, random frames, drain and verdict
   initial begin
      int frame_len;
      logic [7:0] d;
      logic l;
      int random_sent;
      random_sent = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_payload(directed_rows[i].data, directed_rows[i].last,
                      directed_rows[i].byte_count, directed_rows[i].line_seq);
      end

      // Mostly short frames, some long; some closing bytes force a stuffed check
      while (random_sent < RANDOM_ITEMS) begin
         frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48)
                                                 : $urandom_range(1, 8);
         for (int k = 0; k < frame_len; k++) begin
            d = random_payload();
            l = (k == frame_len - 1);
            if (l && $urandom_range(0, 4) == 0) begin
               d = (frame_open ? xor_check : FLAG_BYTE)
                   ^ (($urandom_range(0, 1) == 1) ? FLAG_BYTE : ESC_BYTE);
            end
            send_payload(d, l, 3'd0, 48'h0);
            random_sent++;
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (line_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("byte_stuffing_framer_xor_check_test passed");
      end else begin
         $display("byte_stuffing_framer_xor_check_test failed");
      end
      $finish;
   end

   // Hard stop well beyond the slowest correct run
   initial begin
      #5_000_000;
      $display("byte_stuffing_framer_xor_check_test failed");
      $finish;
   end

endmodule

FILE: files.f
design/bsf_pkg.sv
design/bsf_front.sv
design/bsf_queue.sv
design/bsf_back.sv
design/byte_stuffing_framer_xor_check.sv
dv/byte_stuffing_framer_xor_check_test.sv
